FILE: hdl/salru_pkg.sv
// Shared constants, register codes and types for the set-associative LRU cache lookup.
// No dependencies; used by every module under hdl/.
`timescale 1ns / 1ps

package salru_pkg;

    localparam int WAYS     = 4;
    localparam int MAX_SETS = 512;
    localparam int ENTRIES  = MAX_SETS * WAYS;

    localparam int ENTRY_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int SET_W   = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    // floor(log2(MAX_SETS)): most index bits the store can take
    localparam int IDX_BITS_MAX = $clog2(MAX_SETS + 1) - 1;

    localparam int ADDR_W    = 32;
    localparam int TAG_W     = 32;
    localparam int STAMP_W   = 32;
    localparam int CNT_W     = 32;
    localparam int CFG_W     = 4;
    localparam int OUT_WAY_W = 4;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_BITS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SET_BITS    = 1'b1;

    localparam logic [CFG_W-1:0] OFFSET_BITS_RESET = 4'd6;
    localparam logic [CFG_W-1:0] SET_BITS_RESET    = 4'd4;

    typedef struct packed {
        logic               valid;
        logic [TAG_W-1:0]   tag;
        logic [STAMP_W-1:0] stamp;
    } entry_t;

    typedef struct packed {
        logic             clr;
        logic             en;
        logic [WAY_W-1:0] way;
    } scan_ctl_t;

    typedef struct packed {
        logic             hit;
        logic [WAY_W-1:0] hit_way;
        logic             free_found;
        logic [WAY_W-1:0] free_way;
        logic [WAY_W-1:0] lru_way;
    } scan_res_t;

endpackage

FILE: hdl/set_assoc_cache_lru_lookup.sv
// Set-associative cache lookup with LRU replacement: top level and sequencer.
// Depends on salru_pkg, salru_store and salru_scan.
`timescale 1ns / 1ps

// An address word is taken when start is high and busy is low. The ways of the
// addressed set are read from the entry store one per cycle and checked by a single
// shared compare unit; after the accepting edge busy stays high through the scan,
// drain and finish states; done pulses for one cycle with hit, way_used
// and the saturating totals in the cycle busy is low again, and must be taken then,
// since the result cannot be held off. After reset the block clears the valid bits
// of all MAX_SETS * WAYS entries, one entry a cycle, with busy high; register
// writes on the cfg port are taken at any time and should be made while idle.
module set_assoc_cache_lru_lookup (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [salru_pkg::ADDR_W-1:0]     address,
    output logic                             done,
    output logic                             hit,
    output logic [salru_pkg::OUT_WAY_W-1:0]  way_used,
    output logic [salru_pkg::CNT_W-1:0]      hits_total,
    output logic [salru_pkg::CNT_W-1:0]      misses_total,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [salru_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [salru_pkg::CFG_W-1:0]      cfg_data
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    state_t                               state_reg;
    logic [salru_pkg::ENTRY_W-1:0]        clr_cnt_reg;
    logic [salru_pkg::WAY_W-1:0]          way_cnt_reg;
    logic                                 rd_pend_reg;
    logic [salru_pkg::WAY_W-1:0]          rd_way_reg;
    logic [salru_pkg::ENTRY_W-1:0]        base_reg;
    logic [salru_pkg::TAG_W-1:0]          tag_reg;
    logic [salru_pkg::STAMP_W-1:0]        clock_reg;
    logic [salru_pkg::CNT_W-1:0]          hits_reg;
    logic [salru_pkg::CNT_W-1:0]          misses_reg;
    logic [salru_pkg::CFG_W-1:0]          offset_bits_reg;
    logic [salru_pkg::CFG_W-1:0]          set_bits_reg;
    logic                                 done_reg;
    logic                                 hit_reg;
    logic [salru_pkg::OUT_WAY_W-1:0]      way_used_reg;

    logic                                 accept;
    logic [salru_pkg::CFG_W-1:0]          sb;
    logic [4:0]                           tag_shift;
    logic [salru_pkg::ADDR_W-1:0]         set_field;
    logic [salru_pkg::SET_W-1:0]          set_idx;
    logic [salru_pkg::ENTRY_W-1:0]        base_next;
    logic [salru_pkg::WAY_W-1:0]          victim;
    logic [salru_pkg::CNT_W-1:0]          hits_next;
    logic [salru_pkg::CNT_W-1:0]          misses_next;

    logic                                 wr_en;
    logic [salru_pkg::ENTRY_W-1:0]        wr_addr;
    salru_pkg::entry_t                    wr_data;
    logic                                 rd_en;
    logic [salru_pkg::ENTRY_W-1:0]        rd_addr;
    salru_pkg::entry_t                    rd_data;
    salru_pkg::scan_ctl_t                 scan_ctl;
    salru_pkg::scan_res_t                 scan_res;

    assign busy      = (state_reg != ST_IDLE);
    assign accept    = start && !busy;
    assign cfg_ready = 1'b1;

    // address split
    assign sb        = (set_bits_reg > salru_pkg::CFG_W'(salru_pkg::IDX_BITS_MAX))
                     ? salru_pkg::CFG_W'(salru_pkg::IDX_BITS_MAX) : set_bits_reg;
    assign tag_shift = 5'(offset_bits_reg) + 5'(sb);
    assign set_field = (address >> offset_bits_reg) & ~({salru_pkg::ADDR_W{1'b1}} << sb);
    assign set_idx   = set_field[salru_pkg::SET_W-1:0];
    assign base_next = salru_pkg::ENTRY_W'(salru_pkg::ENTRY_W'(set_idx)
                     * salru_pkg::ENTRY_W'(salru_pkg::WAYS));

    assign victim = scan_res.hit ? scan_res.hit_way
                  : (scan_res.free_found ? scan_res.free_way : scan_res.lru_way);

    assign hits_next   = (scan_res.hit && (hits_reg != '1)) ? hits_reg + 1'b1 : hits_reg;
    assign misses_next = (!scan_res.hit && (misses_reg != '1))
                       ? misses_reg + 1'b1 : misses_reg;

    // store ports: clear sweep and refill share the write port
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = clr_cnt_reg;
        wr_data = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                wr_en = 1'b1;
            end
            ST_FINISH:
            begin
                wr_en         = 1'b1;
                wr_addr       = base_reg + salru_pkg::ENTRY_W'(victim);
                wr_data.valid = 1'b1;
                wr_data.tag   = tag_reg;
                wr_data.stamp = clock_reg;
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    assign rd_en   = (state_reg == ST_SCAN);
    assign rd_addr = base_reg + salru_pkg::ENTRY_W'(way_cnt_reg);

    assign scan_ctl.clr = accept;
    assign scan_ctl.en  = rd_pend_reg;
    assign scan_ctl.way = rd_way_reg;

    salru_store u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    salru_scan u_scan (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (scan_ctl),
        .tag   (tag_reg),
        .entry (rd_data),
        .res   (scan_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_CLEAR;
            clr_cnt_reg     <= '0;
            way_cnt_reg     <= '0;
            rd_pend_reg     <= 1'b0;
            rd_way_reg      <= '0;
            clock_reg       <= '0;
            hits_reg        <= '0;
            misses_reg      <= '0;
            offset_bits_reg <= salru_pkg::OFFSET_BITS_RESET;
            set_bits_reg    <= salru_pkg::SET_BITS_RESET;
            done_reg        <= 1'b0;
            hit_reg         <= 1'b0;
            way_used_reg    <= '0;
        end
        else
        begin
            done_reg    <= 1'b0;
            rd_pend_reg <= 1'b0;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    salru_pkg::REG_OFFSET_BITS: offset_bits_reg <= cfg_data;
                    salru_pkg::REG_SET_BITS:    set_bits_reg    <= cfg_data;
                    default:                    set_bits_reg    <= set_bits_reg;
                endcase
            end
            case (state_reg)
                ST_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (clr_cnt_reg == salru_pkg::ENTRY_W'(salru_pkg::ENTRIES - 1))
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        clock_reg   <= clock_reg + 1'b1;
                        way_cnt_reg <= '0;
                        state_reg   <= ST_SCAN;
                    end
                end
                ST_SCAN:
                begin
                    rd_pend_reg <= 1'b1;
                    rd_way_reg  <= way_cnt_reg;
                    way_cnt_reg <= way_cnt_reg + 1'b1;
                    if (way_cnt_reg == salru_pkg::WAY_W'(salru_pkg::WAYS - 1))
                    begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN:
                begin
                    state_reg <= ST_FINISH;
                end
                ST_FINISH:
                begin
                    hits_reg     <= hits_next;
                    misses_reg   <= misses_next;
                    hit_reg      <= scan_res.hit;
                    way_used_reg <= salru_pkg::OUT_WAY_W'(victim);
                    done_reg     <= 1'b1;
                    state_reg    <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // address split is payload, held for the whole lookup
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            base_reg <= base_next;
            tag_reg  <= address >> tag_shift;
        end
    end

    assign done         = done_reg;
    assign hit          = hit_reg;
    assign way_used     = way_used_reg;
    assign hits_total   = hits_reg;
    assign misses_total = misses_reg;

    a_one_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done high two cycles in a row");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not raise busy");

    a_done_count: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (hits_total != '0 || misses_total != '0))
        else $error("result shown with both totals zero");

    a_way_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (way_used < salru_pkg::OUT_WAY_W'(salru_pkg::WAYS)))
        else $error("way_used out of range");

endmodule

FILE: hdl/salru_store.sv
// Entry store: one word per (set, way) holding valid, tag and use stamp.
// One write port, one read port with registered read data. Uses salru_pkg.
`timescale 1ns / 1ps

module salru_store (
    input  logic                           clk,
    input  logic                           wr_en,
    input  logic [salru_pkg::ENTRY_W-1:0]  wr_addr,
    input  salru_pkg::entry_t              wr_data,
    input  logic                           rd_en,
    input  logic [salru_pkg::ENTRY_W-1:0]  rd_addr,
    output salru_pkg::entry_t              rd_data
);

    salru_pkg::entry_t mem [salru_pkg::ENTRIES];
    salru_pkg::entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hdl/salru_scan.sv
// Shared way evaluator: one tag compare and one stamp compare per cycle, accumulating
// first hit, first free way and oldest way over the ways of one set. Uses salru_pkg.
`timescale 1ns / 1ps

module salru_scan (
    input  logic                           clk,
    input  logic                           rst_n,
    input  salru_pkg::scan_ctl_t           ctl,
    input  logic [salru_pkg::TAG_W-1:0]    tag,
    input  salru_pkg::entry_t              entry,
    output salru_pkg::scan_res_t           res
);

    salru_pkg::scan_res_t              res_reg;
    salru_pkg::scan_res_t              res_next;
    logic [salru_pkg::STAMP_W-1:0]     lru_stamp_reg;
    logic [salru_pkg::STAMP_W-1:0]     lru_stamp_next;
    logic                              tag_eq;
    logic                              older;

    assign tag_eq = (entry.tag == tag);
    // way 0 seeds the search; strict less keeps the lowest way on ties
    assign older  = (ctl.way == '0) || (entry.stamp < lru_stamp_reg);

    always_comb
    begin
        res_next       = res_reg;
        lru_stamp_next = lru_stamp_reg;
        if (ctl.clr)
        begin
            res_next       = '0;
            lru_stamp_next = '0;
        end
        else if (ctl.en)
        begin
            if (entry.valid && tag_eq && !res_reg.hit)
            begin
                res_next.hit     = 1'b1;
                res_next.hit_way = ctl.way;
            end
            if (!entry.valid && !res_reg.free_found)
            begin
                res_next.free_found = 1'b1;
                res_next.free_way   = ctl.way;
            end
            if (entry.valid && older)
            begin
                res_next.lru_way = ctl.way;
                lru_stamp_next   = entry.stamp;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_reg       <= '0;
            lru_stamp_reg <= '0;
        end
        else
        begin
            res_reg       <= res_next;
            lru_stamp_reg <= lru_stamp_next;
        end
    end

    assign res = res_reg;

endmodule
